>>> rtl/tcec_pkg.sv
// ----------------------------------------------------------------------------
// tcec_pkg
// Shared types, constants and the code-to-index tables of the encoder counter.
// ----------------------------------------------------------------------------
package tcec_pkg;

  localparam int unsigned DefCountWidth = 32;
  localparam int unsigned LoadWidth     = 32;
  localparam int unsigned TickOutWidth  = 32;
  localparam int unsigned StepWidth     = 3;
  localparam int unsigned InDataWidth   = 40;   // 35 field bits, padded to bytes
  localparam int unsigned OutDataWidth  = 40;   // 37 field bits, padded to bytes

  typedef logic [2:0] code_t;
  typedef logic [2:0] index_t;

  // index code marking "no table entry"; real indices stay in 0..5
  localparam index_t NoIndex = 3'd7;
  localparam index_t WrapNormal = 3'd5;
  localparam index_t WrapBroken = 3'd3;

  typedef enum logic [1:0] {
    MODE_ALL_GOOD = 2'd0,
    MODE_A_BROKEN = 2'd1,
    MODE_B_BROKEN = 2'd2,
    MODE_C_BROKEN = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_LOAD   = 1'b1
  } kind_t;

  localparam logic [StepWidth-1:0] StepZero   = 3'b000;
  localparam logic [StepWidth-1:0] StepPlus1  = 3'b001;
  localparam logic [StepWidth-1:0] StepPlus2  = 3'b010;
  localparam logic [StepWidth-1:0] StepMinus1 = 3'b111;
  localparam logic [StepWidth-1:0] StepMinus2 = 3'b110;

  // decode outcome for one item
  typedef struct packed {
    logic [StepWidth-1:0] step;
    logic                 code_invalid;
    logic                 jump_rejected;
    logic                 capture;       // last_code takes the sample, sync set
    logic                 count;         // ticks take the stepped value
  } dec_t;

  function automatic index_t idx_lookup(input mode_t mode, input code_t code);
    index_t idx;
    idx = NoIndex;
    case (mode)
      MODE_ALL_GOOD: begin
        case (code)
          3'd1: idx = 3'd5;
          3'd2: idx = 3'd3;
          3'd3: idx = 3'd4;
          3'd4: idx = 3'd1;
          3'd5: idx = 3'd0;
          3'd6: idx = 3'd2;
          default: idx = NoIndex;
        endcase
      end
      MODE_A_BROKEN: begin
        case (code)
          3'd0, 3'd4: idx = 3'd0;
          3'd1, 3'd5: idx = 3'd3;
          3'd2, 3'd6: idx = 3'd1;
          default:    idx = 3'd2;
        endcase
      end
      MODE_B_BROKEN: begin
        case (code)
          3'd0, 3'd2: idx = 3'd0;
          3'd1, 3'd3: idx = 3'd1;
          3'd4, 3'd6: idx = 3'd3;
          default:    idx = 3'd2;
        endcase
      end
      default: begin
        case (code)
          3'd0, 3'd1: idx = 3'd0;
          3'd2, 3'd3: idx = 3'd3;
          3'd4, 3'd5: idx = 3'd1;
          default:    idx = 3'd2;
        endcase
      end
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/tcec_decode.sv
// ----------------------------------------------------------------------------
// tcec_decode
// Table lookup, adjacency check and next tick count for one registered item.
// ----------------------------------------------------------------------------
module tcec_decode #(
  parameter int unsigned COUNT_WIDTH = tcec_pkg::DefCountWidth
) (
  input  tcec_pkg::mode_t                  mode,
  input  tcec_pkg::kind_t                  kind,
  input  tcec_pkg::code_t                  code,
  input  logic [tcec_pkg::LoadWidth-1:0]   load_value,
  input  tcec_pkg::code_t                  last_code,
  input  logic                             code_synced,
  input  logic [COUNT_WIDTH-1:0]           ticks,
  output tcec_pkg::dec_t                   dec,
  output logic [COUNT_WIDTH-1:0]           ticks_next
);
  import tcec_pkg::*;

  index_t            nidx;
  index_t            pidx;
  index_t            wrap;
  logic signed [3:0] delta;
  logic              adjacent;
  logic              forward;
  logic              double_step;

  always_comb begin
    nidx        = idx_lookup(mode, code);
    pidx        = idx_lookup(mode, last_code);
    wrap        = (mode == MODE_ALL_GOOD) ? WrapNormal : WrapBroken;
    delta       = signed'({1'b0, nidx}) - signed'({1'b0, pidx});
    adjacent    = (delta == 4'sd1) || (delta == -4'sd1) ||
                  (delta == signed'({1'b0, wrap})) || (delta == -signed'({1'b0, wrap}));
    forward     = (delta == 4'sd1) || (delta == -signed'({1'b0, wrap}));
    double_step = (mode != MODE_ALL_GOOD) && ((pidx == 3'd0) || (nidx == 3'd0));
  end

  always_comb begin
    dec = '0;
    dec.step = StepZero;
    if (kind == KIND_SAMPLE) begin
      if (nidx == NoIndex) begin
        dec.code_invalid = 1'b1;
      end else if (!code_synced || pidx == NoIndex) begin
        // first valid sample, or stale code after a mode change
        dec.capture = 1'b1;
      end else if (adjacent) begin
        dec.capture = 1'b1;
        dec.count   = 1'b1;
        if (forward) begin
          dec.step = double_step ? StepPlus2 : StepPlus1;
        end else begin
          dec.step = double_step ? StepMinus2 : StepMinus1;
        end
      end else if (delta != 4'sd0) begin
        dec.jump_rejected = 1'b1;
      end
    end
  end

  always_comb begin
    if (kind == KIND_LOAD) begin
      ticks_next = COUNT_WIDTH'(signed'(load_value));
    end else if (dec.count) begin
      ticks_next = ticks + COUNT_WIDTH'(signed'(dec.step));
    end else begin
      ticks_next = ticks;
    end
  end

endmodule

>>> rtl/three_channel_encoder_counter.sv
// ----------------------------------------------------------------------------
// three_channel_encoder_counter
// Three-line encoder decoder with signed tick count and broken-line modes.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit first)
// s_axis    in   tuser: kind ; tdata: line_a, line_b, line_c, load_value[31:0]
// m_axis    out  tdata: tick_count[31:0], step[2:0], code_invalid, jump_rejected
// cfg       in   cfg_wr_data: broken_line_mode
//
// One item per clock while m_axis accepts; from input transfer to result valid: an input
// register, then the table lookup and tick adder feeding the result register.
// Each stage loads when empty or when the stage after it moves, so a stalled
// m_axis holds the result while one more item waits in the input register.
// rst (synchronous) clears valids, code state, tick count and mode.
// ----------------------------------------------------------------------------
module three_channel_encoder_counter #(
  parameter int unsigned COUNT_WIDTH = tcec_pkg::DefCountWidth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_wr_data,   // broken_line_mode
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // line_a, line_b, line_c, load_value[31:0], zero pad
  input  logic [tcec_pkg::InDataWidth-1:0]    s_axis_tdata,
  input  logic                                s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tick_count[31:0], step[2:0], code_invalid, jump_rejected, zero pad
  output logic [tcec_pkg::OutDataWidth-1:0]   m_axis_tdata
);
  import tcec_pkg::*;

  mode_t                  mode;

  // input register
  logic                   in_valid;
  kind_t                  in_kind;
  code_t                  in_code;
  logic [LoadWidth-1:0]   in_load;

  // decoder state
  code_t                  last_code;
  logic                   code_synced;
  logic [COUNT_WIDTH-1:0] ticks;

  // result register
  logic                   out_valid;
  logic [StepWidth-1:0]   out_step;
  logic                   out_invalid;
  logic                   out_rejected;

  dec_t                   dec;
  logic [COUNT_WIDTH-1:0] ticks_next;
  logic                   adv;
  logic                   take;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  tcec_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .mode        (mode),
    .kind        (in_kind),
    .code        (in_code),
    .load_value  (in_load),
    .last_code   (last_code),
    .code_synced (code_synced),
    .ticks       (ticks),
    .dec         (dec),
    .ticks_next  (ticks_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ALL_GOOD;
    end else if (cfg_wr_en) begin
      mode <= mode_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_kind <= kind_t'(s_axis_tuser);
      in_code <= s_axis_tdata[2:0];
      in_load <= s_axis_tdata[LoadWidth+2:3];
    end
  end

  // state advances only when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code   <= '0;
      code_synced <= 1'b0;
      ticks       <= '0;
    end else if (in_valid && adv) begin
      ticks <= ticks_next;
      if (dec.capture) begin
        last_code   <= in_code;
        code_synced <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv) begin
      out_step     <= dec.step;
      out_invalid  <= dec.code_invalid;
      out_rejected <= dec.jump_rejected;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (OutDataWidth - TickOutWidth - StepWidth - 2)'(0),
    out_rejected,
    out_invalid,
    out_step,
    TickOutWidth'(signed'(ticks))
  };

  // a bad code never moves the code state
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && dec.code_invalid) |=> ($stable(last_code) && $stable(code_synced)))
    else $error("code state changed on invalid code");

  // a rejected jump leaves the count alone
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && dec.jump_rejected) |=> $stable(ticks))
    else $error("ticks changed on rejected jump");

  // double steps only exist with a broken line
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && (dec.step == StepPlus2 || dec.step == StepMinus2))
      |-> (mode != MODE_ALL_GOOD))
    else $error("double step in normal mode");

  // a flagged result never carries a step
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_invalid || out_rejected)) |-> (out_step == StepZero))
    else $error("flagged result with nonzero step");

endmodule
